[design/fat_chain_table_engine_unit_defines.svh]
// Assertion macros for the link table engine checker.
// Needs clk and rst_n in the scope that uses them.
`ifndef FAT_CHAIN_TABLE_ENGINE_UNIT_DEFINES_SVH
`define FAT_CHAIN_TABLE_ENGINE_UNIT_DEFINES_SVH

// same-cycle implication, ignored during reset
`define FCT_CHK_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, ignored during reset
`define FCT_CHK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

// next-cycle implication, live through reset
`define FCT_CHK_RST(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

[design/fct_pkg.sv]
// Shared types and codes for the link table engine.
// No dependencies.
package fct_pkg;

  localparam logic [15:0] LINK_END  = 16'hFFFF;
  localparam int          DBC_W     = 14;
  localparam logic [DBC_W-1:0] DBC_RESET = 14'd8192;

  localparam logic [2:0] REQ_WRITE = 3'd0;
  localparam logic [2:0] REQ_READ  = 3'd1;
  localparam logic [2:0] REQ_ALLOC = 3'd2;
  localparam logic [2:0] REQ_FREE  = 3'd3;
  localparam logic [2:0] REQ_WALK  = 3'd4;
  localparam logic [2:0] REQ_COUNT = 3'd5;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NO_FREE = 2'd1;
  localparam logic [1:0] ST_RANGE   = 2'd2;
  localparam logic [1:0] ST_BROKEN  = 2'd3;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [15:0] entry_index;
    logic [15:0] entry_value;
    logic [15:0] skip_count;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] result_value;
  } out_item_t;

  typedef struct packed {
    logic     valid;
    out_item_t item;
  } resp_t;

  typedef struct packed {
    logic        rd_en;
    logic [15:0] rd_addr;
    logic        wr_en;
    logic [15:0] wr_addr;
    logic [15:0] wr_data;
  } mem_cmd_t;

endpackage

[design/fct_mem.sv]
// Link table storage: one write port, one registered read port.
// Depends on fct_pkg for the command struct.
module fct_mem #(
  parameter int DEPTH = 8192
) (
  input  logic              clk,
  input  fct_pkg::mem_cmd_t cmd,
  output logic [15:0]       rd_data
);
  import fct_pkg::*;

  localparam int AW = $clog2(DEPTH);

  logic [15:0] mem [0:DEPTH-1];
  logic [15:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[cmd.wr_addr[AW-1:0]] <= cmd.wr_data;
    end
    if (cmd.rd_en) begin
      rd_data_r <= mem[cmd.rd_addr[AW-1:0]];
    end
  end

  assign rd_data = rd_data_r;

endmodule

[design/fct_ctrl.sv]
// Request sequencer: clearing pass, scans, chain walks and table updates.
// Depends on fct_pkg; drives fct_mem and hands results to the top level.
module fct_ctrl #(
  parameter int ENTRIES = 8192
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  input  fct_pkg::in_item_t        in_data,
  output logic                     in_stall,
  input  logic [fct_pkg::DBC_W-1:0] dbc,
  output fct_pkg::resp_t           resp,
  input  logic                     resp_ready,
  output fct_pkg::mem_cmd_t        mem_cmd,
  input  logic [15:0]              mem_rd_data
);
  import fct_pkg::*;

  localparam int CW = $clog2(ENTRIES + 1);
  localparam int IW = $clog2(ENTRIES);
  localparam logic [15:0]   E16 = 16'(ENTRIES);
  localparam logic [CW-1:0] ECW = CW'(ENTRIES);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_START, S_RD_WAIT, S_SCAN, S_ALLOC_LINK, S_ALLOC_MARK,
    S_FREE_CHK, S_FREE_RD, S_WALK_CHK, S_WALK_RD, S_RESP
  } state_t;

  state_t        state_r, state_nxt;
  in_item_t      req_r, req_nxt;
  logic [15:0]   cur_r, cur_nxt;
  logic [CW-1:0] n_r, n_nxt;
  logic [CW-1:0] ptr_r, ptr_nxt;
  logic          pend_r, pend_nxt;
  logic [IW-1:0] pend_addr_r, pend_addr_nxt;
  out_item_t     res_r, res_nxt;

  logic [15:0]   dbc16, lim16;
  logic [CW-1:0] lim;
  logic [15:0]   n16;

  assign dbc16 = 16'(dbc);
  assign lim16 = (dbc16 < E16) ? dbc16 : E16;
  assign lim   = lim16[CW-1:0];
  assign n16   = 16'(n_r);

  assign in_stall   = (state_r != S_IDLE);
  assign resp.valid = (state_r == S_RESP);
  assign resp.item  = res_r;

  always_comb begin
    state_nxt     = state_r;
    req_nxt       = req_r;
    cur_nxt       = cur_r;
    n_nxt         = n_r;
    ptr_nxt       = ptr_r;
    pend_nxt      = pend_r;
    pend_addr_nxt = pend_addr_r;
    res_nxt       = res_r;
    mem_cmd       = '0;

    case (state_r)
      S_CLEAR: begin
        mem_cmd.wr_en   = 1'b1;
        mem_cmd.wr_addr = 16'(ptr_r);
        mem_cmd.wr_data = '0;
        if (ptr_r == ECW - CW'(1)) begin
          ptr_nxt   = '0;
          state_nxt = S_IDLE;
        end else begin
          ptr_nxt = ptr_r + CW'(1);
        end
      end

      S_IDLE: begin
        if (in_valid) begin
          req_nxt   = in_data;
          state_nxt = S_START;
        end
      end

      S_START: begin
        state_nxt = S_RESP;
        res_nxt   = '{status: ST_OK, result_value: 16'd0};
        case (req_r.req_type)
          REQ_WRITE: begin
            if (req_r.entry_index >= E16) begin
              res_nxt.status = ST_RANGE;
            end else begin
              mem_cmd.wr_en        = 1'b1;
              mem_cmd.wr_addr      = req_r.entry_index;
              mem_cmd.wr_data      = req_r.entry_value;
              res_nxt.result_value = req_r.entry_value;
            end
          end
          REQ_READ: begin
            if (req_r.entry_index >= E16) begin
              res_nxt.status = ST_RANGE;
            end else begin
              mem_cmd.rd_en   = 1'b1;
              mem_cmd.rd_addr = req_r.entry_index;
              state_nxt       = S_RD_WAIT;
            end
          end
          REQ_ALLOC: begin
            if (req_r.entry_index != LINK_END && req_r.entry_index >= E16) begin
              res_nxt.status = ST_RANGE;
            end else begin
              ptr_nxt   = '0;
              pend_nxt  = 1'b0;
              state_nxt = S_SCAN;
            end
          end
          REQ_FREE: begin
            cur_nxt   = req_r.entry_index;
            n_nxt     = '0;
            state_nxt = S_FREE_CHK;
          end
          REQ_WALK: begin
            cur_nxt   = req_r.entry_index;
            n_nxt     = '0;
            state_nxt = S_WALK_CHK;
          end
          REQ_COUNT: begin
            ptr_nxt   = '0;
            pend_nxt  = 1'b0;
            n_nxt     = '0;
            state_nxt = S_SCAN;
          end
          default: ;
        endcase
      end

      S_RD_WAIT: begin
        res_nxt   = '{status: ST_OK, result_value: mem_rd_data};
        state_nxt = S_RESP;
      end

      // one read issued per cycle below the bound; data checked when the registered read returns
      S_SCAN: begin
        if (req_r.req_type == REQ_ALLOC && pend_r && mem_rd_data == 16'd0) begin
          pend_nxt = 1'b0;
          if (pend_addr_r == '0) begin
            res_nxt   = '{status: ST_NO_FREE, result_value: 16'd0};
            state_nxt = S_RESP;
          end else begin
            cur_nxt   = 16'(pend_addr_r);
            state_nxt = S_ALLOC_LINK;
          end
        end else begin
          if (pend_r && mem_rd_data == 16'd0) begin
            n_nxt = n_r + CW'(1);
          end
          if (ptr_r < lim) begin
            mem_cmd.rd_en   = 1'b1;
            mem_cmd.rd_addr = 16'(ptr_r);
            pend_nxt        = 1'b1;
            pend_addr_nxt   = ptr_r[IW-1:0];
            ptr_nxt         = ptr_r + CW'(1);
          end else begin
            pend_nxt = 1'b0;
            if (!pend_r) begin
              state_nxt = S_RESP;
              if (req_r.req_type == REQ_ALLOC) begin
                res_nxt = '{status: ST_NO_FREE, result_value: 16'd0};
              end else begin
                res_nxt = '{status: ST_OK, result_value: n16};
              end
            end
          end
        end
      end

      S_ALLOC_LINK: begin
        if (req_r.entry_index != LINK_END) begin
          mem_cmd.wr_en   = 1'b1;
          mem_cmd.wr_addr = req_r.entry_index;
          mem_cmd.wr_data = cur_r;
        end
        state_nxt = S_ALLOC_MARK;
      end

      // mark after linking, so a tail equal to the new entry ends as end-of-chain
      S_ALLOC_MARK: begin
        mem_cmd.wr_en   = 1'b1;
        mem_cmd.wr_addr = cur_r;
        mem_cmd.wr_data = LINK_END;
        res_nxt         = '{status: ST_OK, result_value: cur_r};
        state_nxt       = S_RESP;
      end

      S_FREE_CHK: begin
        if (cur_r == LINK_END) begin
          res_nxt   = '{status: ST_OK, result_value: n16};
          state_nxt = S_RESP;
        end else if (cur_r >= E16) begin
          res_nxt   = '{status: ST_RANGE, result_value: n16};
          state_nxt = S_RESP;
        end else if (n_r == ECW) begin
          res_nxt   = '{status: ST_BROKEN, result_value: n16};
          state_nxt = S_RESP;
        end else begin
          mem_cmd.rd_en   = 1'b1;
          mem_cmd.rd_addr = cur_r;
          state_nxt       = S_FREE_RD;
        end
      end

      S_FREE_RD: begin
        mem_cmd.wr_en   = 1'b1;
        mem_cmd.wr_addr = cur_r;
        mem_cmd.wr_data = '0;
        cur_nxt         = mem_rd_data;
        n_nxt           = n_r + CW'(1);
        state_nxt       = S_FREE_CHK;
      end

      S_WALK_CHK: begin
        state_nxt = S_RESP;
        if (n16 >= req_r.skip_count || cur_r == LINK_END) begin
          res_nxt = '{status: ST_OK, result_value: cur_r};
        end else if (cur_r >= E16) begin
          res_nxt = '{status: ST_RANGE, result_value: 16'd0};
        end else if (n_r == ECW) begin
          res_nxt = '{status: ST_BROKEN, result_value: 16'd0};
        end else begin
          mem_cmd.rd_en   = 1'b1;
          mem_cmd.rd_addr = cur_r;
          state_nxt       = S_WALK_RD;
        end
      end

      S_WALK_RD: begin
        cur_nxt   = mem_rd_data;
        n_nxt     = n_r + CW'(1);
        state_nxt = S_WALK_CHK;
      end

      S_RESP: begin
        if (resp_ready) begin
          state_nxt = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      ptr_r   <= '0;
      pend_r  <= 1'b0;
      n_r     <= '0;
    end else begin
      state_r <= state_nxt;
      ptr_r   <= ptr_nxt;
      pend_r  <= pend_nxt;
      n_r     <= n_nxt;
    end
    req_r       <= req_nxt;
    cur_r       <= cur_nxt;
    pend_addr_r <= pend_addr_nxt;
    res_r       <= res_nxt;
  end

endmodule

[design/fat_chain_table_engine_unit.sv]
// Link table engine top level: configuration register, result register,
// sequencer and table memory. Depends on fct_pkg, fct_ctrl and fct_mem.
//
// Keeps a table of ENTRIES 16-bit links in one single-port-read, single-port-
// write memory and serves one request at a time. After reset a clearing pass
// writes zero to every entry, one per cycle, while the input stays stalled
// (configuration writes are taken meanwhile). Because the memory has a single
// read port, scans read one entry per cycle and each chain step waits for its
// read. The result register lets the next request enter while a result is
// still stalled at the output.
module fat_chain_table_engine_unit #(
  parameter int ENTRIES = 8192
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  fct_pkg::in_item_t         in_data,
  output logic                      out_valid,
  input  logic                      out_stall,
  output fct_pkg::out_item_t        out_data,
  input  logic                      cfg_wr_en,
  input  logic [fct_pkg::DBC_W-1:0] cfg_wr_data
);
  import fct_pkg::*;

  logic [DBC_W-1:0] dbc_r;
  logic             out_valid_r, out_valid_nxt;
  out_item_t        out_data_r, out_data_nxt;
  resp_t            resp;
  logic             resp_ready;
  mem_cmd_t         mem_cmd;
  logic [15:0]      mem_rd_data;

  fct_ctrl #(.ENTRIES(ENTRIES)) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_data    (in_data),
    .in_stall   (in_stall),
    .dbc        (dbc_r),
    .resp       (resp),
    .resp_ready (resp_ready),
    .mem_cmd    (mem_cmd),
    .mem_rd_data(mem_rd_data)
  );

  fct_mem #(.DEPTH(ENTRIES)) u_mem (
    .clk    (clk),
    .cmd    (mem_cmd),
    .rd_data(mem_rd_data)
  );

  assign resp_ready = !out_valid_r || !out_stall;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (resp.valid && resp_ready) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = resp.item;
    end else if (!out_stall) begin
      // drop after the transfer
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dbc_r       <= DBC_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        dbc_r <= cfg_wr_data;
      end
      out_valid_r <= out_valid_nxt;
    end
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

[design/fct_chk.sv]
// Port-level checker for the link table engine, bound to the top level.
// Depends on fct_pkg and fat_chain_table_engine_unit_defines.svh.
`include "fat_chain_table_engine_unit_defines.svh"

module fct_chk (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input fct_pkg::out_item_t out_data
);
  import fct_pkg::*;

  // clearing pass holds off input; nothing comes out of reset
  `FCT_CHK_RST(a_reset_quiet, !rst_n, in_stall && !out_valid, "busy or valid after reset")

  // one request at a time
  `FCT_CHK_NEXT(a_one_at_a_time, in_valid && !in_stall, in_stall, "second transfer taken")

  // only allocation reports no free entry, and then with a zero result
  `FCT_CHK_NOW(a_nofree_zero, out_valid && out_data.status == ST_NO_FREE,
               out_data.result_value == 16'd0, "no-free result not zero")

  `FCT_CHK_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data),
                "stalled result changed")

endmodule

bind fat_chain_table_engine_unit fct_chk u_fct_chk (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_valid (in_valid),
  .in_stall (in_stall),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .out_data (out_data)
);

[verif/fct_result_checker.sv]
// Result checker for the link table engine: watches both channels and the
// configuration port, predicts each result and compares it on transfer.
// Depends on fct_pkg.
module fct_result_checker #(
  parameter int ENTRIES = 8192
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  input  logic                      in_stall,
  input  fct_pkg::in_item_t         in_data,
  input  logic                      out_valid,
  input  logic                      out_stall,
  input  fct_pkg::out_item_t        out_data,
  input  logic                      cfg_wr_en,
  input  logic [fct_pkg::DBC_W-1:0] cfg_wr_data,
  output int                        fail_count,
  output int                        pending,
  output int                        results_seen
);
  import fct_pkg::*;

  logic [15:0] link_mem [ENTRIES];
  int          dbc_now;
  out_item_t   due_results [$];

  initial begin
    fail_count   = 0;
    pending      = 0;
    results_seen = 0;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("MISMATCH %s: got 0x%0h, expected 0x%0h", what, got, want);
    fail_count++;
  endtask

  // Apply one request to the shadow table and return the result it causes.
  function automatic out_item_t serve_request(input in_item_t rq);
    out_item_t res;
    int        idx;
    int        nxt;
    int        n;
    int        fresh;
    int        lim;
    bit        found;
    res.status       = ST_OK;
    res.result_value = '0;
    idx              = rq.entry_index;
    case (rq.req_type)
      REQ_WRITE: begin
        if (idx >= ENTRIES) begin
          res.status = ST_RANGE;
        end else begin
          link_mem[idx]    = rq.entry_value;
          res.result_value = rq.entry_value;
        end
      end
      REQ_READ: begin
        if (idx >= ENTRIES) res.status = ST_RANGE;
        else res.result_value = link_mem[idx];
      end
      REQ_ALLOC: begin
        if (idx != LINK_END && idx >= ENTRIES) begin
          res.status = ST_RANGE;
        end else begin
          found = 1'b0;
          fresh = 0;
          for (int i = 0; i < ENTRIES; i++) begin
            if (link_mem[i] == 16'd0) begin
              fresh = i;
              found = 1'b1;
              break;
            end
          end
          if (!found || fresh == 0 || fresh >= dbc_now) begin
            res.status = ST_NO_FREE;
          end else begin
            // link the tail first, so a tail equal to the new entry ends as end-of-chain
            if (idx != LINK_END) link_mem[idx] = fresh[15:0];
            link_mem[fresh]  = LINK_END;
            res.result_value = fresh[15:0];
          end
        end
      end
      REQ_FREE: begin
        n = 0;
        while (idx != LINK_END) begin
          if (idx >= ENTRIES) begin
            res.status = ST_RANGE;
            break;
          end
          if (n >= ENTRIES) begin
            res.status = ST_BROKEN;
            break;
          end
          nxt           = link_mem[idx];
          link_mem[idx] = '0;
          n++;
          idx = nxt;
        end
        // freed count is reported even when the chain stops early
        res.result_value = n[15:0];
      end
      REQ_WALK: begin
        for (n = 0; n < rq.skip_count; n++) begin
          if (idx == LINK_END) break;
          if (idx >= ENTRIES) begin
            res.status = ST_RANGE;
            break;
          end
          if (n >= ENTRIES) begin
            res.status = ST_BROKEN;
            break;
          end
          idx = link_mem[idx];
        end
        if (res.status == ST_OK) res.result_value = idx[15:0];
      end
      REQ_COUNT: begin
        lim = (dbc_now < ENTRIES) ? dbc_now : ENTRIES;
        n   = 0;
        for (int i = 0; i < lim; i++) begin
          if (link_mem[i] == 16'd0) n++;
        end
        res.result_value = n[15:0];
      end
      default: ;
    endcase
    return res;
  endfunction

  always @(posedge clk) begin : watch
    out_item_t want;
    if (!rst_n) begin
      foreach (link_mem[i]) link_mem[i] = '0;
      dbc_now = DBC_RESET;
      due_results.delete();
    end else begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (due_results.size() == 0) begin
          report_mismatch("unexpected result", out_data, 0);
        end else begin
          want = due_results.pop_front();
          if (out_data.status !== want.status)
            report_mismatch("status", out_data.status, want.status);
          if (out_data.result_value !== want.result_value)
            report_mismatch("result_value", out_data.result_value, want.result_value);
        end
      end
      if (in_valid && !in_stall) due_results.push_back(serve_request(in_data));
      if (cfg_wr_en) dbc_now = cfg_wr_data;
    end
    pending = due_results.size();
  end

endmodule

[verif/fat_chain_table_engine_unit_tb.sv]
// Testbench top for the link table engine: clock, reset, request stimulus,
// output stall pattern, watchdog and verdict. Depends on fct_pkg,
// fat_chain_table_engine_unit and fct_result_checker.
module fat_chain_table_engine_unit_tb;
  import fct_pkg::*;

  localparam int ENTRIES     = 8192;
  localparam int IDLE_LIMIT  = 200000;
  localparam int HOLD_CYCLES = 300;
  localparam int PHASE_ITEMS = 17;

  logic             clk;
  logic             rst_n;
  logic             in_valid;
  logic             in_stall;
  in_item_t         in_data;
  logic             out_valid;
  logic             out_stall;
  out_item_t        out_data;
  logic             cfg_wr_en;
  logic [DBC_W-1:0] cfg_wr_data;

  int fail_count;
  int pending;
  int results_seen;
  int sent;
  int settings;
  int idle_cycles;
  bit calm;
  bit hold_req;

  fat_chain_table_engine_unit #(.ENTRIES(ENTRIES)) i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  fct_result_checker #(.ENTRIES(ENTRIES)) i_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .fail_count  (fail_count),
    .pending     (pending),
    .results_seen(results_seen)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Output side: random stalls, one long hold-off on request.
  initial begin : result_sink
    int  hold_left;
    bit  hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && !hold_done) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= !calm && ($urandom_range(99) < 6);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles, %0d results due", idle_cycles, pending);
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  function automatic in_item_t mk_req(input logic [2:0] req, input logic [15:0] idx,
                                      input logic [15:0] val, input logic [15:0] skip);
    in_item_t it;
    it.req_type    = req;
    it.entry_index = idx;
    it.entry_value = val;
    it.skip_count  = skip;
    return it;
  endfunction

  // Mostly low entries so that chains overlap, with some out-of-range noise.
  function automatic logic [15:0] pick_index();
    int r;
    r = $urandom_range(99);
    if (r < 80) return 16'($urandom_range(0, 63));
    if (r < 88) return LINK_END;
    if (r < 94) return 16'($urandom_range(ENTRIES, 65534));
    return 16'($urandom_range(0, 65535));
  endfunction

  function automatic logic [15:0] pick_value();
    int r;
    r = $urandom_range(99);
    if (r < 55) return 16'($urandom_range(1, 63));
    if (r < 70) return LINK_END;
    if (r < 80) return 16'd0;
    return 16'($urandom_range(0, 65535));
  endfunction

  function automatic in_item_t rand_req();
    int r;
    r = $urandom_range(99);
    if (r < 32)
      return mk_req(REQ_ALLOC, pick_index(), 16'($urandom_range(0, 65535)), 16'd0);
    if (r < 50) return mk_req(REQ_WRITE, pick_index(), pick_value(), 16'd0);
    if (r < 62) return mk_req(REQ_READ, pick_index(), 16'd0, 16'd0);
    if (r < 80)
      return mk_req(REQ_WALK, pick_index(), 16'd0,
                    16'(($urandom_range(9) < 8) ? $urandom_range(0, 15)
                                                 : $urandom_range(0, 65535)));
    if (r < 89) return mk_req(REQ_COUNT, 16'($urandom_range(0, 65535)), 16'd0, 16'd0);
    return mk_req(3'($urandom_range(0, 7)), 16'($urandom_range(0, 65535)),
                  16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
  endfunction

  // Offer one request and hold it until the transfer; returns at a falling edge.
  task automatic send_req(input in_item_t it);
    while (!calm && $urandom_range(99) < 6) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent++;
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic set_dbc(input int v);
    drain();
    repeat (8) @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v[DBC_W-1:0];
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    settings++;
  endtask

  initial begin : stimulus
    int phase_dbc [4];
    in_valid    = 1'b0;
    in_data     = '0;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = '0;
    rst_n       = 1'b0;
    calm        = 1'b0;
    hold_req    = 1'b0;
    sent        = 0;
    settings    = 0;
    idle_cycles = 0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed part, full data block count
    set_dbc(8192);
    send_req(mk_req(REQ_ALLOC, LINK_END, 16'h0, 16'h0));   // entry 0 free: refused
    send_req(mk_req(REQ_COUNT, 16'h0, 16'h0, 16'h0));
    send_req(mk_req(REQ_WRITE, 16'd0, LINK_END, 16'h0));   // reserve entry 0
    send_req(mk_req(REQ_ALLOC, LINK_END, 16'h0, 16'h0));
    send_req(mk_req(REQ_ALLOC, 16'd1, 16'h0, 16'h0));
    send_req(mk_req(REQ_ALLOC, 16'd2, 16'h0, 16'h0));
    send_req(mk_req(REQ_ALLOC, 16'd4, 16'h0, 16'h0));      // tail is the new entry
    send_req(mk_req(REQ_WALK, 16'd1, 16'h0, 16'd0));
    send_req(mk_req(REQ_WALK, 16'd1, 16'h0, 16'd2));
    send_req(mk_req(REQ_WALK, 16'd1, 16'h0, 16'hFFFF));    // stops at end of chain
    send_req(mk_req(REQ_WRITE, 16'd8192, 16'hAAAA, 16'h0));
    send_req(mk_req(REQ_READ, 16'hFFFF, 16'h0, 16'h0));
    send_req(mk_req(REQ_WRITE, 16'd8191, 16'h5555, 16'h0));
    send_req(mk_req(REQ_READ, 16'd8191, 16'h0, 16'h0));
    send_req(mk_req(REQ_ALLOC, 16'hFFFE, 16'h0, 16'h0));
    send_req(mk_req(REQ_FREE, LINK_END, 16'h0, 16'h0));
    send_req(mk_req(REQ_WRITE, 16'd10, 16'h8000, 16'h0));
    send_req(mk_req(REQ_WALK, 16'd10, 16'h0, 16'd2));      // bad link on the way
    send_req(mk_req(REQ_FREE, 16'd10, 16'h0, 16'h0));
    send_req(mk_req(REQ_FREE, 16'd1, 16'h0, 16'h0));
    send_req(mk_req(REQ_WRITE, 16'd20, 16'd20, 16'h0));    // self loop
    send_req(mk_req(REQ_WALK, 16'd20, 16'h0, 16'hFFFF));
    send_req(mk_req(REQ_WRITE, 16'd0, 16'd0, 16'h0));
    send_req(mk_req(REQ_FREE, 16'd0, 16'h0, 16'h0));       // never reaches an end
    send_req(mk_req(3'd6, 16'h1234, 16'h5678, 16'h9ABC));
    send_req(mk_req(3'd7, 16'hFFFF, 16'hFFFF, 16'hFFFF));

    // data block count of one
    set_dbc(1);
    send_req(mk_req(REQ_ALLOC, LINK_END, 16'h0, 16'h0));
    send_req(mk_req(REQ_WRITE, 16'd0, LINK_END, 16'h0));
    send_req(mk_req(REQ_ALLOC, 16'd3, 16'h0, 16'h0));
    send_req(mk_req(REQ_COUNT, 16'h0, 16'h0, 16'h0));

    phase_dbc[0] = 8192;
    phase_dbc[1] = 48;
    phase_dbc[2] = $urandom_range(1, 8192);
    phase_dbc[3] = 8192;
    for (int p = 0; p < 4; p++) begin
      set_dbc(phase_dbc[p]);
      calm = (p == 2);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if ($urandom_range(99) < 14) begin
          // free a chain with entry 0 reserved as a stop
          send_req(mk_req(REQ_WRITE, 16'd0, LINK_END, 16'($urandom_range(0, 65535))));
          send_req(mk_req(REQ_FREE, pick_index(), 16'($urandom_range(0, 65535)),
                          16'($urandom_range(0, 65535))));
        end else begin
          send_req(rand_req());
        end
        if (p == 1 && k == 4) hold_req = 1'b1;
      end
    end
    calm = 1'b0;

    drain();
    repeat (50) @(negedge clk);
    $display("Summary: %0d requests sent, %0d results checked, %0d register settings",
             sent, results_seen, settings);
    $display("Covered chain building, walks, frees, counts, bad links, loops and a long hold-off");
    if (fail_count == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
